// ===== rtl/core/performance_level_vote_aggregator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the performance level vote aggregator
// ----------------------------------------------------------------------------
`ifndef PERFORMANCE_LEVEL_VOTE_AGGREGATOR_TOP_MACROS_SVH
`define PERFORMANCE_LEVEL_VOTE_AGGREGATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PV_ASSERT_SAME(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define PV_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/core/pvote_pkg.sv =====
// ----------------------------------------------------------------------------
// pvote_pkg
// Shared constants and types for the performance level vote aggregator.
// ----------------------------------------------------------------------------
package pvote_pkg;

    localparam int PV_NUM_CLIENTS = 16;
    localparam int PV_NUM_LEVELS  = 8;
    localparam int PV_MAP_W       = 16;   // width of a level's client bitmap
    localparam int PV_LEVEL_W     = 5;
    localparam int PV_CLIENT_W    = 5;

    localparam logic [PV_LEVEL_W-1:0] PV_UNREQ = 5'h1F;   // -1

    localparam logic PV_OP_SET   = 1'b0;
    localparam logic PV_OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        PV_IDLE,
        PV_SWEEP,
        PV_DONE
    } t_pv_state;

endpackage

// ===== rtl/core/pvote_level_match.sv =====
// ----------------------------------------------------------------------------
// pvote_level_match
// Shared compare unit: bitmap of the clients whose request equals one level.
// ----------------------------------------------------------------------------
module pvote_level_match
    import pvote_pkg::*;
#(
    parameter int NUM_CLIENTS = PV_NUM_CLIENTS,
    parameter int NUM_LEVELS  = PV_NUM_LEVELS,
    localparam int LVL_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1
) (
    input  logic [NUM_CLIENTS-1:0][PV_LEVEL_W-1:0] i_requests,
    input  logic [LVL_W-1:0]                       i_level,
    output logic [PV_MAP_W-1:0]                    o_bitmap
);

    // clients past the bitmap width never count
    localparam int MAP_CLIENTS = (NUM_CLIENTS < PV_MAP_W) ? NUM_CLIENTS : PV_MAP_W;

    logic [PV_LEVEL_W-1:0] w_level_ext;

    assign w_level_ext = PV_LEVEL_W'(i_level);

    genvar c;
    generate
        for (c = 0; c < PV_MAP_W; c++) begin : g_bit
            if (c < MAP_CLIENTS) begin : g_cmp
                // unrequested (-1) has the sign bit set and never matches
                assign o_bitmap[c] = (i_requests[c] == w_level_ext);
            end else begin : g_none
                assign o_bitmap[c] = 1'b0;
            end
        end
    endgenerate

endmodule

// ===== rtl/core/performance_level_vote_aggregator_top.sv =====
// ----------------------------------------------------------------------------
// performance_level_vote_aggregator_top
// Per-client performance level votes with lowest-level winner search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the item on i_operation/i_client/i_level/
//   i_clients_mask with start high; the transfer happens on an edge where
//   busy is low. busy stays high until the result has been shown.
//   Result channel: o_valid is high for exactly one cycle with
//   o_winning_level, o_rejected and o_winning_clients. The receiver cannot
//   stall; it must take the result in that cycle.
//   Sequence: a set or query passes from idle through the level sweep
//   to the result strobe; a rejected set goes from idle straight to the
//   strobe. The next item may be transferred in the cycle after the
//   strobe, so a new item is not taken while one is in progress. The
//   sweep visits the levels in order: one shared compare unit handles
//   one level per cycle, rebuilding that level's bitmap on a set and
//   testing it for the winner; a query tests its stored, masked bitmap.
//   Reset (i_rst_n low, synchronous) marks every client unrequested, clears
//   all level bitmaps and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module performance_level_vote_aggregator_top
    import pvote_pkg::*;
#(
    parameter int NUM_CLIENTS = PV_NUM_CLIENTS,
    parameter int NUM_LEVELS  = PV_NUM_LEVELS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_operation,
    input  logic [PV_CLIENT_W-1:0]       i_client,
    input  logic signed [PV_LEVEL_W-1:0] i_level,
    input  logic [PV_MAP_W-1:0]          i_clients_mask,
    output logic                         o_valid,
    output logic signed [PV_LEVEL_W-1:0] o_winning_level,
    output logic                         o_rejected,
    output logic [PV_MAP_W-1:0]          o_winning_clients
);

    `include "performance_level_vote_aggregator_top_macros.svh"

    localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int CL_W  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam logic [LVL_W-1:0]      LAST_LVL   = LVL_W'(NUM_LEVELS - 1);
    localparam logic [PV_LEVEL_W-1:0] SLOWEST    = PV_LEVEL_W'(NUM_LEVELS - 1);
    localparam logic [PV_CLIENT_W-1:0] CLIENT_LIM = PV_CLIENT_W'(NUM_CLIENTS);
    localparam logic [PV_LEVEL_W-1:0] LEVEL_LIM  = PV_LEVEL_W'(NUM_LEVELS);

    t_pv_state r_state, n_state;

    logic [NUM_CLIENTS-1:0][PV_LEVEL_W-1:0] r_req;
    logic [PV_MAP_W-1:0] r_map [NUM_LEVELS];

    logic                  r_op, n_op;
    logic [PV_MAP_W-1:0]   r_mask, n_mask;
    logic [LVL_W-1:0]      r_lvl, n_lvl;
    logic                  r_found, n_found;
    logic [PV_LEVEL_W-1:0] r_win, n_win;
    logic [PV_MAP_W-1:0]   r_who, n_who;
    logic                  r_rej, n_rej;

    logic                  w_accept;
    logic                  w_reject;
    logic                  w_req_we;
    logic                  w_map_we;
    logic [PV_MAP_W-1:0]   w_built;
    logic [PV_MAP_W-1:0]   w_cand;

    assign w_accept = start && (r_state == PV_IDLE);

    // level below -1, level past the slowest, or client out of range
    assign w_reject = (i_level[PV_LEVEL_W-1] && (i_level != PV_UNREQ))
                   || (!i_level[PV_LEVEL_W-1]
                       && ({1'b0, i_level[PV_LEVEL_W-2:0]} >= LEVEL_LIM))
                   || (i_client >= CLIENT_LIM);

    assign w_req_we = w_accept && (i_operation == PV_OP_SET) && !w_reject;
    assign w_map_we = (r_state == PV_SWEEP) && (r_op == PV_OP_SET);

    pvote_level_match #(
        .NUM_CLIENTS (NUM_CLIENTS),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_match (
        .i_requests (r_req),
        .i_level    (r_lvl),
        .o_bitmap   (w_built)
    );

    // set uses the freshly rebuilt bitmap, query the stored one
    assign w_cand = (r_op == PV_OP_SET) ? w_built : (r_map[r_lvl] & r_mask);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_mask  = r_mask;
        n_lvl   = r_lvl;
        n_found = r_found;
        n_win   = r_win;
        n_who   = r_who;
        n_rej   = r_rej;
        case (r_state)
            PV_IDLE: begin
                if (start) begin
                    n_op    = i_operation;
                    n_mask  = i_clients_mask;
                    n_lvl   = '0;
                    n_found = 1'b0;
                    n_who   = '0;
                    n_win   = PV_UNREQ;
                    if ((i_operation == PV_OP_SET) && w_reject) begin
                        n_rej   = 1'b1;
                        n_state = PV_DONE;
                    end else begin
                        n_rej   = 1'b0;
                        n_state = PV_SWEEP;
                    end
                end
            end
            PV_SWEEP: begin
                if (!r_found && (w_cand != '0)) begin
                    n_found = 1'b1;
                    n_win   = PV_LEVEL_W'(r_lvl);
                    n_who   = w_cand;
                end
                if (r_lvl == LAST_LVL) begin
                    n_state = PV_DONE;
                    if (!r_found && (w_cand == '0)) begin
                        n_win = (r_op == PV_OP_SET) ? PV_UNREQ : SLOWEST;
                    end
                end else begin
                    n_lvl = r_lvl + 1'b1;
                end
            end
            PV_DONE: begin
                n_state = PV_IDLE;
            end
            default: begin
                n_state = PV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PV_IDLE;
            r_found <= 1'b0;
            r_rej   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
            r_rej   <= n_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_mask <= n_mask;
        r_lvl  <= n_lvl;
        r_win  <= n_win;
        r_who  <= n_who;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLIENTS; i++) begin
                r_req[i] <= PV_UNREQ;
            end
        end else if (w_req_we) begin
            r_req[i_client[CL_W-1:0]] <= i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_map[i] <= '0;
            end
        end else if (w_map_we) begin
            r_map[r_lvl] <= w_built;
        end
    end

    assign busy              = (r_state != PV_IDLE);
    assign o_valid           = (r_state == PV_DONE);
    assign o_winning_level   = r_win;
    assign o_rejected        = r_rej;
    assign o_winning_clients = r_who;

    `PV_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted item did not raise busy")
    `PV_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid && !busy, "result strobe not followed by idle")
    `PV_ASSERT_SAME(a_reject_result, i_clk, i_rst_n, o_valid && o_rejected, (o_winning_level == PV_UNREQ) && (o_winning_clients == '0), "rejected set result not cleared")
    `PV_ASSERT_SAME(a_empty_winner, i_clk, i_rst_n, o_valid && !o_rejected && (o_winning_clients == '0), (o_winning_level == PV_UNREQ) || (o_winning_level == SLOWEST), "empty winner with a real level")

endmodule
